// ===== rtl/core/eoc_pkg.sv =====
// Package for the elimination order checker.
// Holds sizes, command and address-source codes, and the controller/datapath structs.
// Depends on nothing.
`timescale 1ns / 1ps

package eoc_pkg;

    // Graph size limits.
    localparam int MAX_VERTICES = 64;
    localparam int VTX_W        = 6;
    localparam int CNT_W        = 7;
    localparam int ROW_W        = 64;
    localparam int CMD_W        = 2;

    // Item command codes.
    localparam logic [CMD_W-1:0] CMD_LOAD_ROW = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET_POS  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN      = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE     = 2'd3;

    // Read address sources for the three memories.
    typedef logic [1:0] t_src;
    localparam t_src SRC_A   = 2'd0;
    localparam t_src SRC_B   = 2'd1;
    localparam t_src SRC_VRD = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic clr_a;
        logic inc_a;
        logic clr_b;
        logic b_from_a;
        logic inc_b;
        logic clr_cnt;
        logic acc_cnt;
        logic upd_best;
        logic cap_piv;
        logic cap_w;
        logic cap_row_w;
        logic set_fail;
        t_src adj_src;
        t_src pos_src;
        t_src vap_src;
    } t_eoc_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic n_zero;
        logic n_lt2;
        logic a_last;
        logic a_next_last;
        logic b_last;
        logic j_hit;
        logic u_fail;
    } t_eoc_stat;

endpackage

// ===== rtl/core/eoc_if.sv =====
// Valid/ready channel interfaces for the elimination order checker.
// Depends on eoc_pkg for field widths.
`timescale 1ns / 1ps

interface eoc_item_if;
    import eoc_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [VTX_W-1:0] vertex;
    logic [VTX_W-1:0] position;
    logic [ROW_W-1:0] neighbours;

    modport source (output valid, cmd, vertex, position, neighbours, input ready);
    modport sink   (input valid, cmd, vertex, position, neighbours, output ready);
endinterface

interface eoc_result_if;
    import eoc_pkg::*;

    logic             valid;
    logic             ready;
    logic [VTX_W-1:0] order_width;
    logic             is_perfect;

    modport source (output valid, order_width, is_perfect, input ready);
    modport sink   (input valid, order_width, is_perfect, output ready);
endinterface

// ===== rtl/core/eoc_dpath.sv =====
// Datapath of the elimination order checker: graph and ordering memories,
// loop counters, pivot registers and the running results. Depends on eoc_pkg.
`timescale 1ns / 1ps

module eoc_dpath (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [eoc_pkg::CNT_W-1:0] i_cfg_wdata,
    input  logic                     i_wr_en,
    input  logic [eoc_pkg::CMD_W-1:0] i_cmd,
    input  logic [eoc_pkg::VTX_W-1:0] i_vertex,
    input  logic [eoc_pkg::VTX_W-1:0] i_position,
    input  logic [eoc_pkg::ROW_W-1:0] i_neighbours,
    input  eoc_pkg::t_eoc_cmd         i_ctl,
    output eoc_pkg::t_eoc_stat        o_stat,
    output logic [eoc_pkg::VTX_W-1:0] o_order_width,
    output logic                     o_is_perfect
);
    import eoc_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] w_n;

    logic [ROW_W-1:0] r_adj_mem [MAX_VERTICES];
    logic [VTX_W-1:0] r_pos_mem [MAX_VERTICES];
    logic [VTX_W-1:0] r_vap_mem [MAX_VERTICES];
    logic [ROW_W-1:0] r_adj_rd;
    logic [VTX_W-1:0] r_pos_rd;
    logic [VTX_W-1:0] r_vap_rd;
    logic [VTX_W-1:0] w_adj_addr;
    logic [VTX_W-1:0] w_pos_addr;
    logic [VTX_W-1:0] w_vap_addr;

    logic [CNT_W-1:0] r_a;
    logic [CNT_W-1:0] r_b;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_best;
    logic             r_perfect;
    logic [ROW_W-1:0] r_row_p;
    logic [VTX_W-1:0] r_pos_p;
    logic [ROW_W-1:0] r_row_w;
    logic [VTX_W-1:0] r_w;

    logic             w_pos_we;
    logic [VTX_W-1:0] w_b_idx;

    // Vertex count register; counts above the maximum act as the maximum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    assign w_n = (r_count > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : r_count;

    // A set-position word is kept only when both vertex and position are in range.
    assign w_pos_we = i_wr_en && (i_cmd == CMD_SET_POS)
                      && ({1'b0, i_vertex} < w_n) && ({1'b0, i_position} < w_n);

    // Read address selection.
    assign w_b_idx    = r_b[VTX_W-1:0];
    assign w_adj_addr = (i_ctl.adj_src == SRC_VRD) ? r_vap_rd : r_a[VTX_W-1:0];
    assign w_vap_addr = (i_ctl.vap_src == SRC_B) ? w_b_idx : r_a[VTX_W-1:0];

    always_comb begin
        case (i_ctl.pos_src)
            SRC_B:   w_pos_addr = w_b_idx;
            SRC_VRD: w_pos_addr = r_vap_rd;
            default: w_pos_addr = r_a[VTX_W-1:0];
        endcase
    end

    // Adjacency row memory.
    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_cmd == CMD_LOAD_ROW)) begin
            r_adj_mem[i_vertex] <= i_neighbours;
        end
        r_adj_rd <= r_adj_mem[w_adj_addr];
    end

    // Position of each vertex.
    always_ff @(posedge i_clk) begin
        if (w_pos_we) begin
            r_pos_mem[i_vertex] <= i_position;
        end
        r_pos_rd <= r_pos_mem[w_pos_addr];
    end

    // Vertex at each position.
    always_ff @(posedge i_clk) begin
        if (w_pos_we) begin
            r_vap_mem[i_position] <= i_vertex;
        end
        r_vap_rd <= r_vap_mem[w_vap_addr];
    end

    // Outer and inner loop counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0;
            r_b <= '0;
        end else begin
            if (i_ctl.start || i_ctl.clr_a) begin
                r_a <= '0;
            end else if (i_ctl.inc_a) begin
                r_a <= r_a + 1'b1;
            end
            if (i_ctl.clr_b) begin
                r_b <= '0;
            end else if (i_ctl.b_from_a) begin
                r_b <= r_a + 1'b1;
            end else if (i_ctl.inc_b) begin
                r_b <= r_b + 1'b1;
            end
        end
    end

    // Pivot vertex, chosen neighbour and running results.
    always_ff @(posedge i_clk) begin
        if (i_ctl.cap_piv) begin
            r_row_p <= r_adj_rd;
            r_pos_p <= r_pos_rd;
        end
        if (i_ctl.cap_w) begin
            r_w <= r_vap_rd;
        end
        if (i_ctl.cap_row_w) begin
            r_row_w <= r_adj_rd;
        end
        if (i_ctl.clr_cnt) begin
            r_cnt <= '0;
        end else if (i_ctl.acc_cnt && r_row_p[w_b_idx] && (r_pos_rd < r_pos_p)) begin
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_ctl.start) begin
            r_best <= '0;
        end else if (i_ctl.upd_best && (r_cnt > r_best)) begin
            r_best <= r_cnt;
        end
        if (i_ctl.start) begin
            r_perfect <= 1'b1;
        end else if (i_ctl.set_fail) begin
            r_perfect <= 1'b0;
        end
    end

    // Loop bounds and test results for the controller.
    assign o_stat.n_zero      = (w_n == '0);
    assign o_stat.n_lt2       = (w_n < CNT_W'(2));
    assign o_stat.a_last      = ((r_a + CNT_W'(1)) == w_n);
    assign o_stat.a_next_last = ((r_a + CNT_W'(2)) >= w_n);
    assign o_stat.b_last      = ((r_b + CNT_W'(1)) >= w_n);
    assign o_stat.j_hit       = r_row_p[r_vap_rd] && ({1'b0, r_vap_rd} < w_n);
    assign o_stat.u_fail      = r_row_p[w_b_idx] && (r_pos_p < r_pos_rd)
                                && (w_b_idx != r_w) && !r_row_w[w_b_idx];

    assign o_order_width = r_best[VTX_W-1:0];
    assign o_is_perfect  = r_perfect;

endmodule

// ===== rtl/core/eoc_ctrl.sv =====
// Controller of the elimination order checker: sequences the width sweep and
// the perfect-order sweep over the datapath. Depends on eoc_pkg.
`timescale 1ns / 1ps

module eoc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_run,
    input  logic               i_out_free,
    input  eoc_pkg::t_eoc_stat i_stat,
    output eoc_pkg::t_eoc_cmd  o_cmd,
    output logic               o_idle,
    output logic               o_done
);
    import eoc_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_W_RDX  = 4'd1;
    localparam logic [3:0] S_W_LATX = 4'd2;
    localparam logic [3:0] S_W_RDU  = 4'd3;
    localparam logic [3:0] S_W_TSTU = 4'd4;
    localparam logic [3:0] S_W_NEXT = 4'd5;
    localparam logic [3:0] S_P_RDV  = 4'd6;
    localparam logic [3:0] S_P_LATV = 4'd7;
    localparam logic [3:0] S_P_LATR = 4'd8;
    localparam logic [3:0] S_P_RDJ  = 4'd9;
    localparam logic [3:0] S_P_TSTJ = 4'd10;
    localparam logic [3:0] S_P_LATW = 4'd11;
    localparam logic [3:0] S_P_RDU  = 4'd12;
    localparam logic [3:0] S_P_TSTU = 4'd13;
    localparam logic [3:0] S_P_NEXT = 4'd14;
    localparam logic [3:0] S_DONE   = 4'd15;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.adj_src = SRC_A;
        o_cmd.pos_src = SRC_A;
        o_cmd.vap_src = SRC_A;
        o_done  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_run) begin
                    o_cmd.start = 1'b1;
                    n_state = i_stat.n_zero ? S_DONE : S_W_RDX;
                end
            end
            // Width sweep: count earlier-placed neighbours of vertex a.
            S_W_RDX: begin
                o_cmd.clr_cnt = 1'b1;
                o_cmd.clr_b   = 1'b1;
                n_state = S_W_LATX;
            end
            S_W_LATX: begin
                o_cmd.cap_piv = 1'b1;
                n_state = S_W_RDU;
            end
            S_W_RDU: begin
                o_cmd.pos_src = SRC_B;
                n_state = S_W_TSTU;
            end
            S_W_TSTU: begin
                o_cmd.acc_cnt = 1'b1;
                o_cmd.inc_b   = 1'b1;
                n_state = i_stat.b_last ? S_W_NEXT : S_W_RDU;
            end
            S_W_NEXT: begin
                o_cmd.upd_best = 1'b1;
                if (i_stat.a_last) begin
                    o_cmd.clr_a = 1'b1;
                    n_state = i_stat.n_lt2 ? S_DONE : S_P_RDV;
                end else begin
                    o_cmd.inc_a = 1'b1;
                    n_state = S_W_RDX;
                end
            end
            // Perfect-order sweep: pivot is the vertex at position a.
            S_P_RDV: begin
                n_state = S_P_LATV;
            end
            S_P_LATV: begin
                o_cmd.adj_src = SRC_VRD;
                o_cmd.pos_src = SRC_VRD;
                n_state = S_P_LATR;
            end
            S_P_LATR: begin
                o_cmd.cap_piv  = 1'b1;
                o_cmd.b_from_a = 1'b1;
                n_state = S_P_RDJ;
            end
            // Find the first later-placed neighbour of the pivot.
            S_P_RDJ: begin
                o_cmd.vap_src = SRC_B;
                n_state = S_P_TSTJ;
            end
            S_P_TSTJ: begin
                if (i_stat.j_hit) begin
                    o_cmd.cap_w   = 1'b1;
                    o_cmd.adj_src = SRC_VRD;
                    n_state = S_P_LATW;
                end else begin
                    o_cmd.inc_b = 1'b1;
                    n_state = i_stat.b_last ? S_P_NEXT : S_P_RDJ;
                end
            end
            S_P_LATW: begin
                o_cmd.cap_row_w = 1'b1;
                o_cmd.clr_b     = 1'b1;
                n_state = S_P_RDU;
            end
            // Every later neighbour of the pivot must also neighbour w.
            S_P_RDU: begin
                o_cmd.pos_src = SRC_B;
                n_state = S_P_TSTU;
            end
            S_P_TSTU: begin
                if (i_stat.u_fail) begin
                    o_cmd.set_fail = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.inc_b = 1'b1;
                    n_state = i_stat.b_last ? S_P_NEXT : S_P_RDU;
                end
            end
            S_P_NEXT: begin
                o_cmd.inc_a = 1'b1;
                n_state = i_stat.a_next_last ? S_DONE : S_P_RDV;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

// ===== rtl/core/elimination_order_checker.sv =====
// Top level of the elimination order checker: controller, datapath and the
// result register. Depends on eoc_pkg, eoc_if, eoc_ctrl and eoc_dpath.
//
// Usage:
//   i_item carries one word per transfer: load an adjacency row (cmd 0), set a
//   vertex position (cmd 1), or run the checks (cmd 2); cmd 3 is dropped.
//   o_result carries one word for each run: order width and perfect flag.
//   i_cfg_we / i_cfg_wdata write the vertex count; write it only while idle.
// Timing:
//   Load and set-position words are taken one per cycle while no run is in
//   progress. A run word keeps the block busy while the controller walks the
//   memories one read per step, each read going through the registered memory
//   port; the run holds the input through its nested vertex loops over them.
// Reset:
//   Synchronous, active low: the vertex count goes to 0, the controller to
//   idle and the result register empties. The memories are not cleared.
// Stall:
//   A finished result waits in the output register; loads are still taken
//   meanwhile, and a following run ends its sweep, then holds until it drains.
`timescale 1ns / 1ps

module elimination_order_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [eoc_pkg::CNT_W-1:0] i_cfg_wdata,
    eoc_item_if.sink                  i_item,
    eoc_result_if.source              o_result
);
    import eoc_pkg::*;

    t_eoc_cmd         w_cmd;
    t_eoc_stat        w_stat;
    logic             w_idle;
    logic             w_done;
    logic             w_accept;
    logic             w_out_free;
    logic [VTX_W-1:0] w_order_width;
    logic             w_is_perfect;

    logic             r_out_valid;
    logic [VTX_W-1:0] r_order_width;
    logic             r_is_perfect;

    // Input handshake: words are taken whenever no run is in progress.
    assign i_item.ready = w_idle;
    assign w_accept     = i_item.valid && w_idle;
    assign w_out_free   = !r_out_valid || o_result.ready;

    eoc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_run      (w_accept && (i_item.cmd == CMD_RUN)),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_idle     (w_idle),
        .o_done     (w_done)
    );

    eoc_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_wr_en       (w_accept),
        .i_cmd         (i_item.cmd),
        .i_vertex      (i_item.vertex),
        .i_position    (i_item.position),
        .i_neighbours  (i_item.neighbours),
        .i_ctl         (w_cmd),
        .o_stat        (w_stat),
        .o_order_width (w_order_width),
        .o_is_perfect  (w_is_perfect)
    );

    // Output register: holds a result until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_order_width <= w_order_width;
            r_is_perfect  <= w_is_perfect;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.order_width = r_order_width;
    assign o_result.is_perfect  = r_is_perfect;

endmodule

// ===== tb/elimination_order_checker_tb.sv =====
// Self-checking testbench for the elimination order checker: loads graphs and
// orderings, runs the checks and compares every result word with a local predictor.
// Depends on eoc_pkg, eoc_if and the elimination_order_checker RTL.
`timescale 1ns / 1ps

module elimination_order_checker_tb;
    import eoc_pkg::*;

    localparam int  SETTLE_CYCLES = 16;
    localparam time TIMEOUT_NS    = 8_000_000;

    // Shapes of the graphs that a phase loads.
    typedef enum int {
        SHAPE_SPARSE,
        SHAPE_CLIQUE,
        SHAPE_TREE,
        SHAPE_NOISE
    } t_graph_shape;

    // One word waiting for the item channel.
    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [VTX_W-1:0] vertex;
        logic [VTX_W-1:0] position;
        logic [ROW_W-1:0] neighbours;
        bit               hold;
    } t_item_word;

    // One predicted result word.
    typedef struct packed {
        logic [VTX_W-1:0] order_width;
        logic             is_perfect;
    } t_run_result;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CNT_W-1:0] i_cfg_wdata;

    eoc_item_if   item_ch ();
    eoc_result_if res_ch ();

    elimination_order_checker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (item_ch),
        .o_result    (res_ch)
    );

    // Predictor state: graph, both ordering tables and the vertex count.
    logic [ROW_W-1:0] graph_rows [MAX_VERTICES];
    logic [VTX_W-1:0] pos_of     [MAX_VERTICES];
    logic [VTX_W-1:0] vtx_at     [MAX_VERTICES];
    logic [CNT_W-1:0] count_now = '0;

    // Stimulus-side view of what has been queued so far.
    logic [ROW_W-1:0]        plan_rows  [MAX_VERTICES];
    logic [VTX_W-1:0]        plan_vtx   [MAX_VERTICES];
    logic [VTX_W-1:0]        plan_order [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] rows_loaded = '0;
    int                      perm_span   = 0;

    t_item_word  pending_words [$];
    t_run_result due_results [$];
    t_item_word  word_out;
    t_run_result due;
    int          words_queued = 0;
    int          words_taken  = 0;
    int          faults       = 0;
    int          send_idle    = 0;
    int          send_calm    = 0;
    int          take_idle    = 0;
    int          take_calm    = 0;
    int          take_draw;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Vertices taking part for a given register value.
    function automatic int live_count(logic [CNT_W-1:0] c);
        return (c > 7'd64) ? MAX_VERTICES : int'(c);
    endfunction

    function automatic logic [ROW_W-1:0] span_mask(int n);
        if (n >= ROW_W)
            return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    function automatic logic linked(logic [VTX_W-1:0] a, logic [VTX_W-1:0] b,
                                    logic [ROW_W-1:0] m);
        logic [ROW_W-1:0] r;
        r = graph_rows[a] & m;
        return r[b];
    endfunction

    // Largest number of neighbours placed before a vertex.
    function automatic logic [VTX_W-1:0] calc_order_width(int n, logic [ROW_W-1:0] m);
        int               best;
        int               cnt;
        logic [ROW_W-1:0] row;
        best = 0;
        for (int x = 0; x < n; x++) begin
            row = graph_rows[x] & m;
            cnt = 0;
            for (int u = 0; u < n; u++)
                if (row[u] && pos_of[u] < pos_of[x])
                    cnt++;
            if (cnt > best)
                best = cnt;
        end
        return VTX_W'(best);
    endfunction

    // Perfect elimination test: every later neighbour of a vertex must touch the
    // first later vertex in the order that is adjacent to it.
    function automatic logic calc_perfect(int n, logic [ROW_W-1:0] m);
        logic [VTX_W-1:0] v;
        logic [VTX_W-1:0] w;
        logic [ROW_W-1:0] row;
        int               j;
        if (n < 2)
            return 1'b1;
        for (int i = 0; i + 1 < n; i++) begin
            v = vtx_at[i];
            j = i + 1;
            while (j < n && !linked(v, vtx_at[j], m))
                j++;
            if (j < n) begin
                w   = vtx_at[j];
                row = graph_rows[v] & m;
                for (int u = 0; u < n; u++)
                    if (row[u] && pos_of[v] < pos_of[u] && u != int'(w) &&
                        !linked(w, VTX_W'(u), m))
                        return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Apply one accepted word to the predictor.
    function automatic void absorb_word(logic [CMD_W-1:0] cmd, logic [VTX_W-1:0] v,
                                        logic [VTX_W-1:0] p, logic [ROW_W-1:0] row);
        int               n;
        logic [ROW_W-1:0] m;
        t_run_result      r;
        n = live_count(count_now);
        m = span_mask(n);
        case (cmd)
            CMD_LOAD_ROW: begin
                graph_rows[v] = row;
            end
            CMD_SET_POS: begin
                if (int'(v) < n && int'(p) < n) begin
                    pos_of[v] = p;
                    vtx_at[p] = v;
                end
            end
            CMD_RUN: begin
                r.order_width = calc_order_width(n, m);
                r.is_perfect  = calc_perfect(n, m);
                due_results.push_back(r);
            end
            default: ;
        endcase
    endfunction

    // Idle cycles before the next word, with stretches of none at all.
    function automatic int draw_idle(ref int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    // Item driver: presents queued words, idling between them. A held word
    // waits until every outstanding run has delivered its result.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
            send_idle     <= 0;
        end else if (!item_ch.valid || item_ch.ready) begin
            if (send_idle > 0) begin
                item_ch.valid <= 1'b0;
                send_idle     <= send_idle - 1;
            end else if (pending_words.size() != 0 &&
                         !(pending_words[0].hold &&
                           (due_results.size() != 0 ||
                            (item_ch.valid && item_ch.cmd == CMD_RUN)))) begin
                word_out            = pending_words.pop_front();
                item_ch.valid      <= 1'b1;
                item_ch.cmd        <= word_out.cmd;
                item_ch.vertex     <= word_out.vertex;
                item_ch.position   <= word_out.position;
                item_ch.neighbours <= word_out.neighbours;
                send_idle          <= draw_idle(send_calm);
            end else begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver: stalls a drawn number of cycles after each word.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            take_idle    <= 0;
        end else if (res_ch.valid && res_ch.ready) begin
            take_draw = draw_idle(take_calm);
            take_idle    <= take_draw;
            res_ch.ready <= (take_draw == 0);
        end else if (take_idle > 0) begin
            take_idle    <= take_idle - 1;
            res_ch.ready <= (take_idle == 1);
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // Monitor: checks result words, then feeds accepted items to the predictor.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                if (due_results.size() == 0) begin
                    $error("result word with no run outstanding: order_width=%0d is_perfect=%0d",
                           res_ch.order_width, res_ch.is_perfect);
                    faults++;
                end else begin
                    due = due_results.pop_front();
                    if (res_ch.order_width !== due.order_width) begin
                        $error("order_width: expected %0d, got %0d",
                               due.order_width, res_ch.order_width);
                        faults++;
                    end
                    if (res_ch.is_perfect !== due.is_perfect) begin
                        $error("is_perfect: expected %0d, got %0d",
                               due.is_perfect, res_ch.is_perfect);
                        faults++;
                    end
                end
            end
            if (item_ch.valid && item_ch.ready) begin
                absorb_word(item_ch.cmd, item_ch.vertex, item_ch.position,
                            item_ch.neighbours);
                words_taken++;
            end
        end
    end

    // Queue one word and track what it leaves in the block's tables.
    function automatic void queue_word(logic [CMD_W-1:0] cmd, logic [VTX_W-1:0] v,
                                       logic [VTX_W-1:0] p, logic [ROW_W-1:0] row,
                                       bit hold = 1'b0);
        t_item_word w;
        int         n;
        w.cmd        = cmd;
        w.vertex     = v;
        w.position   = p;
        w.neighbours = row;
        w.hold       = hold;
        pending_words.push_back(w);
        words_queued++;
        n = live_count(count_now);
        if (cmd == CMD_LOAD_ROW) begin
            plan_rows[v]   = row;
            rows_loaded[v] = 1'b1;
        end else if (cmd == CMD_SET_POS && int'(v) < n && int'(p) < n) begin
            plan_vtx[p] = v;
        end
    endfunction

    function automatic logic [ROW_W-1:0] any_row();
        return {$urandom, $urandom};
    endfunction

    // Any vertex or position number.
    function automatic logic [VTX_W-1:0] any_vtx();
        return VTX_W'($urandom_range(0, 63));
    endfunction

    // Wait until every word is taken and every result has come back.
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (words_taken != words_queued || due_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_vertex_count(input logic [CNT_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        count_now = value;
    endtask

    // One random word: mostly row edits, position swaps and runs.
    function automatic void random_word(int n, bit allow_run);
        int               r;
        int               p1;
        int               p2;
        logic [VTX_W-1:0] v;
        logic [ROW_W-1:0] row;
        r = $urandom_range(0, allow_run ? 99 : 69);
        if (r < 30) begin
            v = (n > 0 && $urandom_range(0, 6) != 0) ? VTX_W'($urandom_range(0, n - 1))
                                                      : any_vtx();
            case ($urandom_range(0, 3))
                0, 1:    row = plan_rows[v] ^ (64'd1 << $urandom_range(0, 63));
                2:       row = any_row();
                default: row = $urandom_range(0, 1) ? '1 : '0;
            endcase
            queue_word(CMD_LOAD_ROW, v, any_vtx(), row);
        end else if (r < 55 && n >= 2) begin
            // Swap two vertices in the order, keeping both tables consistent.
            p1 = $urandom_range(0, n - 1);
            p2 = $urandom_range(0, n - 1);
            v  = plan_vtx[p2];
            queue_word(CMD_SET_POS, plan_vtx[p1], VTX_W'(p2), any_row());
            queue_word(CMD_SET_POS, v, VTX_W'(p1), any_row());
        end else if (r < 65) begin
            queue_word(CMD_SET_POS, any_vtx(), any_vtx(), any_row());
        end else if (r < 70) begin
            queue_word(CMD_NONE, any_vtx(), any_vtx(), any_row());
        end else begin
            queue_word(CMD_RUN, any_vtx(), any_vtx(), any_row(),
                       $urandom_range(0, 3) == 0);
        end
    endfunction

    // One phase: set the count, load a graph and an order where needed, then
    // random words, and always a run at the end.
    task automatic run_phase(input logic [CNT_W-1:0] count, input int extra);
        int               n;
        int               j;
        logic [VTX_W-1:0] t;
        logic [ROW_W-1:0] m;
        bit               big;
        bit               fresh;
        t_graph_shape     shape;
        logic [ROW_W-1:0] g [MAX_VERTICES];
        set_vertex_count(count);
        n     = live_count(count);
        m     = span_mask(n);
        big   = (n > 16);
        fresh = !big || (perm_span < n);

        // Order to build the graph around.
        for (int i = 0; i < MAX_VERTICES; i++)
            plan_order[i] = fresh ? VTX_W'(i) : plan_vtx[i];
        if (fresh) begin
            for (int i = n - 1; i > 0; i--) begin
                j             = $urandom_range(0, i);
                t             = plan_order[i];
                plan_order[i] = plan_order[j];
                plan_order[j] = t;
            end
        end

        // Graph rows; a tree hangs each vertex on a later one, so it passes.
        shape = big ? SHAPE_CLIQUE : t_graph_shape'($urandom_range(0, 3));
        for (int v = 0; v < MAX_VERTICES; v++)
            g[v] = '0;
        for (int a = 0; a < n; a++) begin
            for (int b = a + 1; b < n; b++) begin
                if (shape == SHAPE_CLIQUE ||
                    (shape == SHAPE_SPARSE && $urandom_range(0, 3) == 0)) begin
                    g[a][b] = 1'b1;
                    g[b][a] = 1'b1;
                end
            end
            if (shape == SHAPE_TREE && a + 1 < n) begin
                j = $urandom_range(a + 1, n - 1);
                g[plan_order[a]][plan_order[j]] = 1'b1;
                g[plan_order[j]][plan_order[a]] = 1'b1;
            end
        end
        for (int v = 0; v < n; v++) begin
            if (shape == SHAPE_NOISE)
                g[v] = any_row();
            else if ($urandom_range(0, 1) == 0)
                g[v] = g[v] | (any_row() & ~m);
            if (!big || !rows_loaded[v])
                queue_word(CMD_LOAD_ROW, VTX_W'(v), any_vtx(), g[v]);
        end

        if (fresh) begin
            for (int i = 0; i < n; i++)
                queue_word(CMD_SET_POS, plan_order[i], VTX_W'(i), any_row());
            if (n > perm_span)
                perm_span = n;
        end

        // Large graphs are slow to check, so they get only two runs.
        for (int k = 0; k < extra; k++) begin
            if (big && k == extra / 2)
                queue_word(CMD_RUN, any_vtx(), any_vtx(), any_row());
            else
                random_word(n, !big);
        end
        queue_word(CMD_RUN, any_vtx(), any_vtx(), any_row());
        wait_idle();
    endtask

    // Watchdog.
    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

    // Stimulus.
    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = '0;
        item_ch.valid      = 1'b0;
        item_ch.cmd        = CMD_NONE;
        item_ch.vertex     = '0;
        item_ch.position   = '0;
        item_ch.neighbours = '0;
        res_ch.ready       = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty graph: trivially perfect, unused command and ignored position.
        set_vertex_count(7'd0);
        queue_word(CMD_RUN, 6'd0, 6'd0, '0);
        queue_word(CMD_NONE, 6'd63, 6'd63, '1);
        queue_word(CMD_SET_POS, 6'd0, 6'd0, '0);
        queue_word(CMD_LOAD_ROW, 6'd63, 6'd63, '1);
        queue_word(CMD_LOAD_ROW, 6'd0, 6'd0, '0);
        wait_idle();

        // Single vertex, including a self loop; one word waits for the run.
        set_vertex_count(7'd1);
        queue_word(CMD_SET_POS, 6'd0, 6'd0, '0);
        queue_word(CMD_RUN, 6'd0, 6'd0, '0);
        queue_word(CMD_LOAD_ROW, 6'd0, 6'd0, '1, 1'b1);
        queue_word(CMD_RUN, 6'd63, 6'd63, '1);
        wait_idle();

        // Two vertices: masked row bits, out-of-range positions, and finally
        // two ordering tables that disagree.
        set_vertex_count(7'd2);
        queue_word(CMD_LOAD_ROW, 6'd1, 6'd0, '1);
        queue_word(CMD_LOAD_ROW, 6'd0, 6'd0, 64'h2);
        queue_word(CMD_SET_POS, 6'd1, 6'd0, '0);
        queue_word(CMD_SET_POS, 6'd0, 6'd1, '0);
        queue_word(CMD_RUN, 6'd0, 6'd0, '0);
        queue_word(CMD_SET_POS, 6'd2, 6'd0, '0);
        queue_word(CMD_SET_POS, 6'd0, 6'd2, '0);
        queue_word(CMD_SET_POS, 6'd63, 6'd63, '1);
        queue_word(CMD_RUN, 6'd0, 6'd0, '0);
        queue_word(CMD_LOAD_ROW, 6'd63, 6'd0, 64'h8000_0000_0000_0001);
        queue_word(CMD_SET_POS, 6'd1, 6'd1, '0);
        queue_word(CMD_RUN, 6'd0, 6'd0, '0);
        wait_idle();

        // Random phases across the count range, its extremes among them.
        run_phase(7'd5, 14);
        run_phase(7'd3, 14);
        run_phase(7'd8, 14);
        run_phase(7'd64, 12);
        run_phase(7'd127, 12);
        run_phase(7'd12, 14);
        run_phase(7'd2, 14);
        run_phase(7'd6, 14);
        run_phase(7'd65, 12);
        run_phase(7'd4, 14);
        run_phase(7'd16, 14);
        run_phase(7'd1, 14);
        run_phase(7'd7, 14);
        run_phase(7'd0, 14);

        if (faults == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== elimination_order_checker.f =====
rtl/core/eoc_pkg.sv
rtl/core/eoc_if.sv
rtl/core/eoc_dpath.sv
rtl/core/eoc_ctrl.sv
rtl/core/elimination_order_checker.sv
tb/elimination_order_checker_tb.sv
